/* hw/rtl/rc_stick_deadzone_and_mode_switch_macros.svh */
// ----------------------------------------------------------------------------
// RC stick dead zone and mode switch: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RC_STICK_DEADZONE_AND_MODE_SWITCH_MACROS_SVH
`define RC_STICK_DEADZONE_AND_MODE_SWITCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCSDZ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCSDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rcsdz_pkg.sv */
// ----------------------------------------------------------------------------
// rcsdz_pkg
// Types, widths and constants shared by the stick dead zone and switch logic.
// ----------------------------------------------------------------------------
package rcsdz_pkg;

    localparam int NUM_STICKS   = 4;
    localparam int PULSE_W      = 12;
    localparam int DZ_W         = 9;
    localparam int GAIN_W       = 24;
    localparam int THR_W        = 11;
    localparam int VALUE_W      = 16;
    localparam int EXCESS_W     = 12;
    localparam int PROD_W       = EXCESS_W + GAIN_W;
    localparam int FRAC_SHIFT   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int IN_DATA_W    = 88;
    localparam int OUT_DATA_W   = 72;

    localparam logic [PULSE_W-1:0] STICK_CENTRE_US = 12'd1500;
    localparam logic [PULSE_W-1:0] SWITCH_MAX_US   = 12'd2100;

    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST   = 9'd125;
    localparam logic [GAIN_W-1:0] STICK_GAIN_RST  = 24'd2863312;
    localparam logic [THR_W-1:0]  MODE_THR_RST    = 11'd1750;
    localparam logic [THR_W-1:0]  GEAR_THR_RST    = 11'd1750;
    localparam logic [THR_W-1:0]  REBOOT_THR_RST  = 11'd1500;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_THR = 3'd4;

    typedef struct packed {
        logic hover_active;
        logic hover_entered;
        logic command_active;
        logic command_entered;
        logic reboot_toggle;
        logic range_error;
    } t_sw_flags;

endpackage

/* hw/rtl/rcsdz_stick_lane.sv */
// ----------------------------------------------------------------------------
// rcsdz_stick_lane
// One stick: dead zone removal, reciprocal gain multiply and Q2.14 saturation.
// ----------------------------------------------------------------------------
module rcsdz_stick_lane (
    input  logic                                  i_clk,
    input  logic                                  i_load1,
    input  logic                                  i_load2,
    input  logic [rcsdz_pkg::PULSE_W-1:0]         i_pulse,
    input  logic [rcsdz_pkg::DZ_W-1:0]            i_dead_zone,
    input  logic [rcsdz_pkg::GAIN_W-1:0]          i_gain,
    output logic signed [rcsdz_pkg::VALUE_W-1:0]  o_value
);

    localparam int SW = rcsdz_pkg::PULSE_W + 2;

    logic signed [SW-1:0]                  w_pulse_s;
    logic signed [SW-1:0]                  w_dz_s;
    logic signed [SW-1:0]                  w_centre_s;
    logic signed [SW-1:0]                  w_up;
    logic signed [SW-1:0]                  w_dn;
    logic [rcsdz_pkg::EXCESS_W-1:0]        n_excess;
    logic                                  n_neg;
    logic [rcsdz_pkg::EXCESS_W-1:0]        r_excess;
    logic                                  r_neg1;
    logic [rcsdz_pkg::PROD_W-1:0]          r_prod;
    logic                                  r_neg2;
    logic [rcsdz_pkg::PROD_W-rcsdz_pkg::FRAC_SHIFT-1:0] w_mag;
    logic [rcsdz_pkg::VALUE_W-1:0]         w_mag_sat;

    assign w_pulse_s  = $signed({2'b00, i_pulse});
    assign w_dz_s     = $signed({{(SW-rcsdz_pkg::DZ_W){1'b0}}, i_dead_zone});
    assign w_centre_s = $signed({2'b00, rcsdz_pkg::STICK_CENTRE_US});
    assign w_up       = w_pulse_s - w_centre_s - w_dz_s;
    assign w_dn       = w_centre_s - w_pulse_s - w_dz_s;

    always_comb begin
        priority if (w_up > 0) begin
            n_excess = w_up[rcsdz_pkg::EXCESS_W-1:0];
            n_neg    = 1'b0;
        end else if (w_dn > 0) begin
            n_excess = w_dn[rcsdz_pkg::EXCESS_W-1:0];
            n_neg    = 1'b1;
        end else begin
            n_excess = '0;
            n_neg    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load1) begin
            r_excess <= n_excess;
            r_neg1   <= n_neg;
        end
        if (i_load2) begin
            r_prod <= {{rcsdz_pkg::GAIN_W{1'b0}}, r_excess} *
                      {{rcsdz_pkg::EXCESS_W{1'b0}}, i_gain};
            r_neg2 <= r_neg1;
        end
    end

    assign w_mag = r_prod[rcsdz_pkg::PROD_W-1:rcsdz_pkg::FRAC_SHIFT];

    always_comb begin
        if (|w_mag[$bits(w_mag)-1:rcsdz_pkg::VALUE_W-1]) begin
            w_mag_sat = {1'b0, {(rcsdz_pkg::VALUE_W-1){1'b1}}};
        end else begin
            w_mag_sat = {1'b0, w_mag[rcsdz_pkg::VALUE_W-2:0]};
        end
    end

    assign o_value = r_neg2 ? $signed(-w_mag_sat) : $signed(w_mag_sat);

endmodule

/* hw/rtl/rcsdz_switch.sv */
// ----------------------------------------------------------------------------
// rcsdz_switch
// Mode, gear and reboot switch levels and threshold crossings with history.
// ----------------------------------------------------------------------------
module rcsdz_switch (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [rcsdz_pkg::PULSE_W-1:0] i_mode,
    input  logic [rcsdz_pkg::PULSE_W-1:0] i_gear,
    input  logic [rcsdz_pkg::PULSE_W-1:0] i_reboot,
    input  logic [rcsdz_pkg::THR_W-1:0]   i_thr_mode,
    input  logic [rcsdz_pkg::THR_W-1:0]   i_thr_gear,
    input  logic [rcsdz_pkg::THR_W-1:0]   i_thr_reboot,
    output rcsdz_pkg::t_sw_flags          o_flags
);

    logic [rcsdz_pkg::PULSE_W-1:0] r_prev_mode;
    logic [rcsdz_pkg::PULSE_W-1:0] r_prev_gear;
    logic [rcsdz_pkg::PULSE_W-1:0] r_prev_reboot;
    logic                          r_seen;
    logic                          r_command;
    logic                          r_entry;
    logic                          n_command;
    logic                          n_entry;
    logic [rcsdz_pkg::PULSE_W-1:0] w_pm;
    logic [rcsdz_pkg::PULSE_W-1:0] w_pg;
    logic [rcsdz_pkg::PULSE_W-1:0] w_pr;
    logic [rcsdz_pkg::PULSE_W-1:0] w_tm;
    logic [rcsdz_pkg::PULSE_W-1:0] w_tg;
    logic [rcsdz_pkg::PULSE_W-1:0] w_tr;
    logic                          w_hover;

    // On the first frame the history is taken from the current pulses.
    assign w_pm = r_seen ? r_prev_mode   : i_mode;
    assign w_pg = r_seen ? r_prev_gear   : i_gear;
    assign w_pr = r_seen ? r_prev_reboot : i_reboot;
    assign w_tm = {1'b0, i_thr_mode};
    assign w_tg = {1'b0, i_thr_gear};
    assign w_tr = {1'b0, i_thr_reboot};

    assign w_hover = i_mode > w_tm;

    always_comb begin
        n_command = r_command;
        n_entry   = r_entry;
        if (w_hover) begin
            priority if (w_pg < w_tg && i_gear > w_tg) begin
                n_entry = 1'b1;
            end else if (i_gear < w_tg) begin
                n_entry = 1'b0;
            end else begin
                n_entry = r_entry;
            end
            n_command = i_gear > w_tg;
        end
    end

    assign o_flags.hover_active    = w_hover;
    assign o_flags.hover_entered   = w_hover && (w_pm < w_tm);
    assign o_flags.command_active  = n_command;
    assign o_flags.command_entered = n_entry;
    assign o_flags.reboot_toggle   = !w_hover && !n_command &&
                                     (w_pr < w_tr) && (i_reboot > w_tr);
    assign o_flags.range_error     = (i_mode > rcsdz_pkg::SWITCH_MAX_US) ||
                                     (i_gear > rcsdz_pkg::SWITCH_MAX_US) ||
                                     (i_reboot > rcsdz_pkg::SWITCH_MAX_US);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mode   <= '0;
            r_prev_gear   <= '0;
            r_prev_reboot <= '0;
            r_seen        <= 1'b0;
            r_command     <= 1'b1;
            r_entry       <= 1'b0;
        end else if (i_take) begin
            r_prev_mode   <= i_mode;
            r_prev_gear   <= i_gear;
            r_prev_reboot <= i_reboot;
            r_seen        <= 1'b1;
            r_command     <= n_command;
            r_entry       <= n_entry;
        end
    end

endmodule

/* hw/rtl/rc_stick_deadzone_and_mode_switch.sv */
// Throughput: one request per cycle unless the receiver holds off i_m_tready, set by
// the three-stage stick lane pipeline (dead zone subtract, gain multiply, saturate
// into the output register).
// Reset is synchronous and active low: registers return to their defaults,
// switch history clears, the command flag sets and the pipeline empties.
// ----------------------------------------------------------------------------
// rc_stick_deadzone_and_mode_switch
// Four stick lanes in parallel plus switch edge logic, merged into one result.
// ----------------------------------------------------------------------------
`include "rc_stick_deadzone_and_mode_switch_macros.svh"

module rc_stick_deadzone_and_mode_switch (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rcsdz_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rcsdz_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // Low bit up: stick_pulse_0..3, mode_pulse, gear_pulse, reboot_pulse, zeros.
    input  logic [rcsdz_pkg::IN_DATA_W-1:0]        i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // Low bit up: stick_value_0..3, hover_active, hover_entered, command_active,
    // command_entered, reboot_toggle, sticks_centred, range_error, zero.
    output logic [rcsdz_pkg::OUT_DATA_W-1:0]       o_m_tdata
);

    localparam int NS = rcsdz_pkg::NUM_STICKS;
    localparam int PW = rcsdz_pkg::PULSE_W;
    localparam int VW = rcsdz_pkg::VALUE_W;

    logic [rcsdz_pkg::DZ_W-1:0]   r_dead_zone;
    logic [rcsdz_pkg::GAIN_W-1:0] r_gain;
    logic [rcsdz_pkg::THR_W-1:0]  r_thr_mode;
    logic [rcsdz_pkg::THR_W-1:0]  r_thr_gear;
    logic [rcsdz_pkg::THR_W-1:0]  r_thr_reboot;

    logic                         r_v1;
    logic                         r_v2;
    logic                         r_out_valid;
    logic                         w_rdy1;
    logic                         w_rdy2;
    logic                         w_rdy_out;
    logic                         w_take;
    logic                         w_load2;
    logic                         w_load_out;

    logic [PW-1:0]                w_pulse [NS];
    logic signed [VW-1:0]         w_value [NS];
    logic signed [VW-1:0]         r_out_value [NS];
    logic                         n_centred;
    logic                         r_out_centred;

    rcsdz_pkg::t_sw_flags         w_flags;
    rcsdz_pkg::t_sw_flags         r_flags1;
    rcsdz_pkg::t_sw_flags         r_flags2;
    rcsdz_pkg::t_sw_flags         r_out_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= rcsdz_pkg::DEAD_ZONE_RST;
            r_gain       <= rcsdz_pkg::STICK_GAIN_RST;
            r_thr_mode   <= rcsdz_pkg::MODE_THR_RST;
            r_thr_gear   <= rcsdz_pkg::GEAR_THR_RST;
            r_thr_reboot <= rcsdz_pkg::REBOOT_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcsdz_pkg::CFG_DEAD_ZONE: begin
                    r_dead_zone <= i_cfg_data[rcsdz_pkg::DZ_W-1:0];
                end
                rcsdz_pkg::CFG_STICK_GAIN: begin
                    r_gain <= i_cfg_data[rcsdz_pkg::GAIN_W-1:0];
                end
                rcsdz_pkg::CFG_MODE_THR: begin
                    r_thr_mode <= i_cfg_data[rcsdz_pkg::THR_W-1:0];
                end
                rcsdz_pkg::CFG_GEAR_THR: begin
                    r_thr_gear <= i_cfg_data[rcsdz_pkg::THR_W-1:0];
                end
                rcsdz_pkg::CFG_REBOOT_THR: begin
                    r_thr_reboot <= i_cfg_data[rcsdz_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Each stage advances when the one after it is empty or moving.
    assign w_rdy_out  = !r_out_valid || i_m_tready;
    assign w_rdy2     = !r_v2 || w_rdy_out;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;
    assign w_take     = i_s_tvalid && w_rdy1;
    assign w_load2    = r_v1 && w_rdy2;
    assign w_load_out = r_v2 && w_rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= w_take;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy_out) begin
                r_out_valid <= r_v2;
            end
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_lane
        assign w_pulse[g] = i_s_tdata[g*PW +: PW];

        rcsdz_stick_lane u_lane (
            .i_clk       (i_clk),
            .i_load1     (w_take),
            .i_load2     (w_load2),
            .i_pulse     (w_pulse[g]),
            .i_dead_zone (r_dead_zone),
            .i_gain      (r_gain),
            .o_value     (w_value[g])
        );
    end

    rcsdz_switch u_switch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_mode       (i_s_tdata[NS*PW +: PW]),
        .i_gear       (i_s_tdata[(NS+1)*PW +: PW]),
        .i_reboot     (i_s_tdata[(NS+2)*PW +: PW]),
        .i_thr_mode   (r_thr_mode),
        .i_thr_gear   (r_thr_gear),
        .i_thr_reboot (r_thr_reboot),
        .o_flags      (w_flags)
    );

    always_comb begin
        n_centred = 1'b1;
        for (int k = 0; k < NS; k++) begin
            if (w_value[k] != '0) begin
                n_centred = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_flags1 <= w_flags;
        end
        if (w_load2) begin
            r_flags2 <= r_flags1;
        end
        if (w_load_out) begin
            r_out_flags   <= r_flags2;
            r_out_centred <= n_centred;
            for (int k = 0; k < NS; k++) begin
                r_out_value[k] <= w_value[k];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_m_tdata = '0;
        for (int k = 0; k < NS; k++) begin
            o_m_tdata[k*VW +: VW] = r_out_value[k];
        end
        o_m_tdata[NS*VW + 0] = r_out_flags.hover_active;
        o_m_tdata[NS*VW + 1] = r_out_flags.hover_entered;
        o_m_tdata[NS*VW + 2] = r_out_flags.command_active;
        o_m_tdata[NS*VW + 3] = r_out_flags.command_entered;
        o_m_tdata[NS*VW + 4] = r_out_flags.reboot_toggle;
        o_m_tdata[NS*VW + 5] = r_out_centred;
        o_m_tdata[NS*VW + 6] = r_out_flags.range_error;
    end

    `RCSDZ_ASSERT_SAME(a_centred_merge, r_out_valid, r_out_centred == ((r_out_value[0] == '0) && (r_out_value[1] == '0) && (r_out_value[2] == '0) && (r_out_value[3] == '0)), "centred flag disagrees with stick values")
    `RCSDZ_ASSERT_SAME(a_no_min_value, r_out_valid, (r_out_value[0] != 16'sh8000) && (r_out_value[1] != 16'sh8000) && (r_out_value[2] != 16'sh8000) && (r_out_value[3] != 16'sh8000), "stick value escaped saturation")
    `RCSDZ_ASSERT_NEXT(a_stage1_kept, r_v1 && !w_rdy2, r_v1, "stage one request dropped while stalled")
    `RCSDZ_ASSERT_NEXT(a_stage2_kept, r_v2 && !w_rdy_out, r_v2, "stage two request dropped while stalled")

endmodule

/* sim/rc_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_frame_checker
// Watches the register port and both streams of the stick dead zone and mode
// switch block. Every accepted request is turned into a predicted result from
// a private copy of the registers and switch history, and every delivered
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rc_frame_checker
    import rcsdz_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 10;
    localparam int STICK_SAT   = 32767;
    localparam int NUM_FLAGS   = 7;
    localparam int FLAG_BASE   = NUM_STICKS * VALUE_W;
    localparam int HOVER_BIT   = FLAG_BASE;
    localparam int ENTRY_BIT   = FLAG_BASE + 1;
    localparam int CMD_BIT     = FLAG_BASE + 2;
    localparam int CMD_IN_BIT  = FLAG_BASE + 3;
    localparam int TOGGLE_BIT  = FLAG_BASE + 4;
    localparam int CENTRE_BIT  = FLAG_BASE + 5;
    localparam int RANGE_BIT   = FLAG_BASE + 6;

    logic [DZ_W-1:0]    dz_setting;
    logic [GAIN_W-1:0]  gain;
    logic [THR_W-1:0]   mode_thr;
    logic [THR_W-1:0]   gear_thr;
    logic [THR_W-1:0]   reboot_thr;
    logic [PULSE_W-1:0] prev_mode_p;
    logic [PULSE_W-1:0] prev_gear_p;
    logic [PULSE_W-1:0] prev_reboot_p;
    logic               seen_frame;
    logic               command_flag;
    logic               command_entry;

    logic [OUT_DATA_W-1:0] expected_results [$];
    int mismatches  = 0;
    int outstanding = 0;
    string flag_names [NUM_FLAGS] = '{"hover_active", "hover_entered", "command_active",
                                      "command_entered", "reboot_toggle", "sticks_centred",
                                      "range_error"};

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    function automatic logic [VALUE_W-1:0] deadzone_scale(input logic [PULSE_W-1:0] pulse);
        longint unsigned p;
        longint unsigned dz;
        longint unsigned centre;
        longint unsigned excess;
        longint unsigned mag;
        logic neg;
        p = pulse;
        dz = dz_setting;
        centre = STICK_CENTRE_US;
        if (p > centre + dz) begin
            excess = p - centre - dz;
            neg = 1'b0;
        end else if (p + dz < centre) begin
            excess = centre - dz - p;
            neg = 1'b1;
        end else begin
            return '0;
        end
        mag = (excess * longint'(gain)) >> FRAC_SHIFT;
        if (mag > STICK_SAT)
            mag = STICK_SAT;
        return neg ? VALUE_W'(0 - mag) : VALUE_W'(mag);
    endfunction

    function automatic logic [OUT_DATA_W-1:0] predict_frame_result(
        input logic [IN_DATA_W-1:0] req
    );
        logic [OUT_DATA_W-1:0] res;
        logic [PULSE_W-1:0]    mode_p;
        logic [PULSE_W-1:0]    gear_p;
        logic [PULSE_W-1:0]    reboot_p;
        logic                  hover;
        res = '0;
        mode_p = req[4*PULSE_W +: PULSE_W];
        gear_p = req[5*PULSE_W +: PULSE_W];
        reboot_p = req[6*PULSE_W +: PULSE_W];
        for (int i = 0; i < NUM_STICKS; i++)
            res[i*VALUE_W +: VALUE_W] = deadzone_scale(req[i*PULSE_W +: PULSE_W]);
        if (!seen_frame) begin
            seen_frame = 1'b1;
            prev_mode_p = mode_p;
            prev_gear_p = gear_p;
            prev_reboot_p = reboot_p;
        end
        hover = mode_p > mode_thr;
        res[ENTRY_BIT] = hover && (prev_mode_p < mode_thr);
        if (hover) begin
            if (prev_gear_p < gear_thr && gear_p > gear_thr)
                command_entry = 1'b1;
            else if (gear_p < gear_thr)
                command_entry = 1'b0;
            command_flag = gear_p > gear_thr;
        end
        res[TOGGLE_BIT] = !hover && !command_flag && (prev_reboot_p < reboot_thr) &&
                          (reboot_p > reboot_thr);
        prev_mode_p = mode_p;
        prev_gear_p = gear_p;
        prev_reboot_p = reboot_p;
        res[HOVER_BIT] = hover;
        res[CMD_BIT] = command_flag;
        res[CMD_IN_BIT] = command_entry;
        res[CENTRE_BIT] = (res[FLAG_BASE-1:0] == '0);
        res[RANGE_BIT] = (mode_p > SWITCH_MAX_US) || (gear_p > SWITCH_MAX_US) ||
                         (reboot_p > SWITCH_MAX_US);
        return res;
    endfunction

    task automatic log_failure(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic compare_result(input logic [OUT_DATA_W-1:0] want,
                                  input logic [OUT_DATA_W-1:0] got);
        for (int i = 0; i < NUM_STICKS; i++)
            if (got[i*VALUE_W +: VALUE_W] !== want[i*VALUE_W +: VALUE_W])
                log_failure($sformatf("stick_value_%0d: expected %0d, actual %0d", i,
                                      $signed(want[i*VALUE_W +: VALUE_W]),
                                      $signed(got[i*VALUE_W +: VALUE_W])));
        for (int j = 0; j < NUM_FLAGS; j++)
            if (got[FLAG_BASE+j] !== want[FLAG_BASE+j])
                log_failure($sformatf("%s: expected %b, actual %b", flag_names[j],
                                      want[FLAG_BASE+j], got[FLAG_BASE+j]));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dz_setting = DEAD_ZONE_RST;
            gain = STICK_GAIN_RST;
            mode_thr = MODE_THR_RST;
            gear_thr = GEAR_THR_RST;
            reboot_thr = REBOOT_THR_RST;
            prev_mode_p = '0;
            prev_gear_p = '0;
            prev_reboot_p = '0;
            seen_frame = 1'b0;
            command_flag = 1'b1;
            command_entry = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEAD_ZONE:  dz_setting = i_cfg_data[DZ_W-1:0];
                    CFG_STICK_GAIN: gain = i_cfg_data[GAIN_W-1:0];
                    CFG_MODE_THR:   mode_thr = i_cfg_data[THR_W-1:0];
                    CFG_GEAR_THR:   gear_thr = i_cfg_data[THR_W-1:0];
                    CFG_REBOOT_THR: reboot_thr = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_frame_result(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0)
                    log_failure($sformatf("result %h arrived with no request pending",
                                          i_m_tdata));
                else
                    compare_result(expected_results.pop_front(), i_m_tdata);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the stick dead zone and mode switch block with directed frames at the
// field extremes and switch thresholds, then with random frames under several
// register settings, with random idling, a long receiver hold-off and drained
// pauses. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import rcsdz_pkg::*;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int RANDOM_PER_PHASE = 185;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 8;
    localparam int IDLE_PERCENT     = 33;
    localparam int IN_PAD_W         = IN_DATA_W - 7 * PULSE_W;
    localparam int PULSE_MAX        = (1 << PULSE_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    bit steady_flow = 1'b0;
    bit sink_hold_req = 1'b0;
    int sink_hold_left = 0;
    int dz_now = DEAD_ZONE_RST;
    int mode_thr_now = MODE_THR_RST;
    int gear_thr_now = GEAR_THR_RST;
    int reboot_thr_now = REBOOT_THR_RST;

    rc_stick_deadzone_and_mode_switch dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    rc_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver holds off when asked, otherwise it idles at random unless steady_flow is set.
    always @(posedge i_clk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left <= sink_hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (sink_hold_req) begin
            sink_hold_req <= 1'b0;
            sink_hold_left <= SINK_HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic logic [IN_DATA_W-1:0] mk_frame(input int s0, input int s1, input int s2,
                                                      input int s3, input int mode,
                                                      input int gear, input int reboot);
        return {{IN_PAD_W{1'b0}}, PULSE_W'(reboot), PULSE_W'(gear), PULSE_W'(mode),
                PULSE_W'(s3), PULSE_W'(s2), PULSE_W'(s1), PULSE_W'(s0)};
    endfunction

    function automatic logic [PULSE_W-1:0] clamp_pulse(input int p);
        if (p < 0)
            return '0;
        if (p > PULSE_MAX)
            return PULSE_W'(PULSE_MAX);
        return PULSE_W'(p);
    endfunction

    function automatic logic [PULSE_W-1:0] rand_stick();
        int pick;
        int offset;
        pick = $urandom_range(99);
        if (pick < 40) begin
            offset = dz_now + int'($urandom_range(40)) - 20;
            return clamp_pulse($urandom_range(1) ? 1500 + offset : 1500 - offset);
        end
        if (pick < 75)
            return PULSE_W'($urandom_range(2100, 900));
        return PULSE_W'($urandom_range(PULSE_MAX, 0));
    endfunction

    function automatic logic [PULSE_W-1:0] rand_switch(input int thr);
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return clamp_pulse(thr + int'($urandom_range(4)) - 2);
        if (pick < 75)
            return PULSE_W'($urandom_range(2200, 900));
        if (pick < 85)
            return clamp_pulse(thr + ($urandom_range(1) ? 200 : -200));
        return PULSE_W'($urandom_range(PULSE_MAX, 0));
    endfunction

    task automatic send_frame(input logic [IN_DATA_W-1:0] frame);
        i_s_tdata <= frame;
        i_s_tvalid <= 1'b1;
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic random_frames(input int n);
        for (int k = 0; k < n; k++)
            send_frame({{IN_PAD_W{1'b0}}, rand_switch(reboot_thr_now), rand_switch(gear_thr_now),
                        rand_switch(mode_thr_now), rand_stick(), rand_stick(), rand_stick(),
                        rand_stick()});
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results == 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
    endtask

    task automatic load_config(input int dz, input int unsigned gain, input int mthr,
                               input int gthr, input int rthr);
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_STICK_GAIN, gain);
        write_reg(CFG_MODE_THR, mthr);
        write_reg(CFG_GEAR_THR, gthr);
        write_reg(CFG_REBOOT_THR, rthr);
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
        dz_now = dz;
        mode_thr_now = mthr;
        gear_thr_now = gthr;
        reboot_thr_now = rthr;
    endtask

    initial begin
        int dz;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: dead zone 125, all thresholds as after reset.
        send_frame(mk_frame(1500, 1500, 1500, 1500, 2000, 2000, 2000));
        send_frame(mk_frame(0, 4095, 1625, 1375, 1000, 1000, 1000));
        send_frame(mk_frame(1626, 1374, 4095, 0, 1750, 1750, 1750));
        send_frame(mk_frame(1627, 1373, 2000, 1000, 1751, 1750, 1400));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 1000, 1000, 1000));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 1000, 1000, 1600));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 1000, 1000, 1500));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 1000, 1000, 1501));
        send_frame(mk_frame(1700, 1300, 1500, 1500, 1800, 1000, 1000));
        send_frame(mk_frame(1500, 1500, 1800, 1200, 1800, 1800, 1000));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 1800, 1750, 1000));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 1000, 2000, 1000));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 1000, 1000, 1600));
        send_frame(mk_frame(4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_frame(mk_frame(0, 0, 0, 0, 0, 0, 0));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 2100, 2100, 2100));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 2101, 0, 0));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 0, 2101, 0));
        send_frame(mk_frame(1500, 1500, 1500, 1500, 0, 0, 2101));
        send_frame(mk_frame(2048, 2047, 1024, 1023, 2730, 1365, 3276));
        send_frame(mk_frame(2730, 1365, 3276, 819, 1, 2, 4));
        send_frame(mk_frame(1, 2, 4, 8, 16, 32, 64));
        random_frames(RANDOM_PER_PHASE);

        drain_results();
        load_config(0, 2147483, 1000, 1000, 1000);
        random_frames(RANDOM_PER_PHASE);

        drain_results();
        load_config(500, 24'hFFFFFF, 2000, 2000, 2000);
        random_frames(RANDOM_PER_PHASE);

        drain_results();
        load_config((1 << DZ_W) - 1, 0, (1 << THR_W) - 1, (1 << THR_W) - 1, (1 << THR_W) - 1);
        random_frames(RANDOM_PER_PHASE);

        // A small gain truncates most sticks outside the dead zone to zero.
        drain_results();
        load_config(60, 30, $urandom_range(2000, 1000), $urandom_range(2000, 1000),
                    $urandom_range(2000, 1000));
        random_frames(RANDOM_PER_PHASE);

        drain_results();
        dz = $urandom_range(499, 0);
        load_config(dz, (16384 * 65536) / (500 - dz), $urandom_range(2000, 1000),
                    $urandom_range(2000, 1000), $urandom_range(2000, 1000));
        steady_flow = 1'b1;
        random_frames(RANDOM_PER_PHASE / 2);
        steady_flow = 1'b0;
        random_frames(RANDOM_PER_PHASE / 2);

        drain_results();
        load_config($urandom_range(500, 0), $urandom_range(24'hFFFFFF, 0),
                    $urandom_range(2000, 1000), $urandom_range(2000, 1000),
                    $urandom_range(2000, 1000));
        sink_hold_req = 1'b1;
        random_frames(RANDOM_PER_PHASE);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rcsdz_pkg.sv
hw/rtl/rcsdz_stick_lane.sv
hw/rtl/rcsdz_switch.sv
hw/rtl/rc_stick_deadzone_and_mode_switch.sv
sim/rc_frame_checker.sv
sim/tb.sv
